// File: src/epps_pkg.sv
// shared types, codes and widths of the port sequencer
package epps_pkg;

	// parameter default and fixed field widths
	localparam int ADDRESS_BITS_DEF = 20;
	localparam int ADDR_W           = 20;
	localparam int NUM_STEPS        = 22;
	localparam int STEP_W           = 5;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 24;

	// command codes carried on s_tuser
	localparam logic [3:0] ACT_MODE    = 4'd0;
	localparam logic [3:0] ACT_VCC     = 4'd1;
	localparam logic [3:0] ACT_PULSE   = 4'd2;
	localparam logic [3:0] ACT_VPP     = 4'd3;
	localparam logic [3:0] ACT_ADDRESS = 4'd4;
	localparam logic [3:0] ACT_WRITE   = 4'd5;
	localparam logic [3:0] ACT_READ    = 4'd6;
	localparam logic [3:0] ACT_TRIGGER = 4'd7;
	localparam logic [3:0] ACT_OE      = 4'd8;
	localparam logic [3:0] ACT_RESET   = 4'd9;

	// programmer modes
	localparam logic [1:0] PMODE_NONE  = 2'd0;
	localparam logic [1:0] PMODE_READ  = 2'd1;
	localparam logic [1:0] PMODE_WRITE = 2'd2;

	// vpp selections
	localparam logic [1:0] VPP_12V = 2'd0;
	localparam logic [1:0] VPP_21V = 2'd1;
	localparam logic [1:0] VPP_25V = 2'd2;

	// unit selects
	localparam logic [2:0] UNIT_DATA_LO = 3'd0;
	localparam logic [2:0] UNIT_DATA_HI = 3'd1;
	localparam logic [2:0] UNIT_SERIAL  = 3'd5;
	localparam logic [2:0] UNIT_PULSE   = 3'd6;
	localparam logic [2:0] UNIT_CTRL    = 3'd7;

	// reset value of the kept pulse selection
	localparam logic [1:0] PULSE_RST = 2'd3;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              capture;
		logic              load;
		logic [STEP_W-1:0] step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cur_emit;
		logic rest_empty;
		logic rest_after_empty;
		logic out_free;
	} dp_stat_t;

endpackage

// File: src/epps_dp.sv
// datapath: kept selections, command registers, write generator, output register
module epps_dp #(
	parameter int ADDRESS_BITS = epps_pkg::ADDRESS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [epps_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic [epps_pkg::S_TDATA_W-1:0] s_tdata,
	input  epps_pkg::ctrl_cmd_t            cmd,
	output epps_pkg::dp_stat_t             stat,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [epps_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);

	localparam int AW = epps_pkg::ADDR_W;
	localparam int NS = epps_pkg::NUM_STEPS;
	localparam int SW = epps_pkg::STEP_W;

	localparam logic [AW:0] AMASK_EXT = ((AW+1)'(1) << ADDRESS_BITS) - (AW+1)'(1);
	localparam logic [AW-1:0] AMASK = AMASK_EXT[AW-1:0];

	// step slots: header 0-1, nibbles 2-4, serial 5-20, trailer 21
	localparam logic [NS-1:0] MASK_HEAD  = NS'(3);
	localparam logic [NS-1:0] MASK_ONE   = NS'(1);
	localparam logic [NS-1:0] MASK_TAIL  = NS'(1) << (NS - 1);
	localparam logic [NS-1:0] MASK_READ  = NS'(8'hFF);
	localparam logic [NS-1:0] MASK_TRIG  = NS'(5'h1F);

	// input fields
	logic [3:0]    in_act;
	logic [2:0]    in_mv;
	logic [AW-1:0] in_addr;
	logic [7:0]    in_data;
	logic          in_en;
	logic [7:0]    in_rb;
	logic          in_pd;

	assign in_act  = s_tuser;
	assign in_mv   = s_tdata[2:0];
	assign in_addr = s_tdata[22:3];
	assign in_data = s_tdata[30:23];
	assign in_en   = s_tdata[31];
	assign in_rb   = s_tdata[39:32];
	assign in_pd   = s_tdata[40];

	// kept state
	logic [1:0]              mode_q;
	logic                    vcc_q;
	logic [1:0]              pulse_q;
	logic [1:0]              vpp_q;
	logic [ADDRESS_BITS-1:0] addr_q;

	// captured command
	logic [3:0]    act_q;
	logic [2:0]    mv_q;
	logic [AW-1:0] naddr_q;
	logic [7:0]    data_q;
	logic          en_q;
	logic [NS-1:0] mask_q;
	logic          ok_q;
	logic [7:0]    rbyte_q;
	logic          pok_q;

	// capture decode
	logic [AW-1:0]           addr_m, tgt, prev;
	logic [2:0]              nib_chg;
	logic                    hi_chg;
	logic [NS-1:0]           addr_mask, mask_n;
	logic                    ok_n;
	logic [1:0]              mode_n, pulse_n, vpp_n;
	logic                    vcc_n;
	logic [ADDRESS_BITS-1:0] addr_n;

	always_comb begin
		addr_m = in_addr & AMASK;
		tgt    = (in_act == epps_pkg::ACT_RESET) ? '0 : addr_m;
		prev   = AW'(addr_q);
		for (int k = 0; k < 3; k++) begin
			nib_chg[k] = prev[4*k +: 4] != tgt[4*k +: 4];
		end
		hi_chg    = prev[AW-1:12] != tgt[AW-1:12];
		addr_mask = {1'b0, {16{hi_chg}}, nib_chg, 2'b00};

		mask_n  = '0;
		ok_n    = 1'b0;
		mode_n  = mode_q;
		vcc_n   = vcc_q;
		pulse_n = pulse_q;
		vpp_n   = vpp_q;
		addr_n  = addr_q;
		unique case (in_act)
			epps_pkg::ACT_MODE: begin
				if (in_mv == 3'(epps_pkg::PMODE_READ)) begin
					ok_n   = 1'b1;
					mask_n = MASK_HEAD;
					mode_n = epps_pkg::PMODE_READ;
				end else if (in_mv == 3'(epps_pkg::PMODE_WRITE)) begin
					ok_n   = 1'b1;
					mask_n = MASK_HEAD;
					mode_n = epps_pkg::PMODE_WRITE;
				end else if (in_mv == 3'(epps_pkg::PMODE_NONE)) begin
					ok_n    = 1'b1;
					mask_n  = MASK_HEAD | MASK_TAIL;
					mode_n  = epps_pkg::PMODE_NONE;
					vcc_n   = 1'b0;
					pulse_n = epps_pkg::PULSE_RST;
					vpp_n   = epps_pkg::VPP_25V;
				end
			end
			epps_pkg::ACT_VCC: begin
				if (in_mv <= 3'd1 && mode_q == epps_pkg::PMODE_NONE) begin
					ok_n  = 1'b1;
					vcc_n = in_mv[0];
				end
			end
			epps_pkg::ACT_PULSE: begin
				if (in_mv <= 3'd3 && mode_q == epps_pkg::PMODE_NONE) begin
					ok_n    = 1'b1;
					pulse_n = in_mv[1:0];
				end
			end
			epps_pkg::ACT_VPP: begin
				if (in_mv <= 3'(epps_pkg::VPP_25V)) begin
					ok_n   = 1'b1;
					mask_n = MASK_TAIL;
					vpp_n  = in_mv[1:0];
				end
			end
			epps_pkg::ACT_ADDRESS: begin
				ok_n   = 1'b1;
				mask_n = addr_mask;
				addr_n = addr_m[ADDRESS_BITS-1:0];
			end
			epps_pkg::ACT_WRITE: begin
				if (mode_q == epps_pkg::PMODE_WRITE) begin
					ok_n   = 1'b1;
					mask_n = MASK_HEAD;
				end
			end
			epps_pkg::ACT_READ: begin
				if (mode_q == epps_pkg::PMODE_READ) begin
					ok_n   = 1'b1;
					mask_n = MASK_READ;
				end
			end
			epps_pkg::ACT_TRIGGER: begin
				if (mode_q == epps_pkg::PMODE_WRITE) begin
					ok_n   = 1'b1;
					mask_n = MASK_TRIG;
				end
			end
			epps_pkg::ACT_OE: begin
				if (mode_q == epps_pkg::PMODE_READ) begin
					ok_n   = 1'b1;
					mask_n = MASK_ONE;
				end
			end
			epps_pkg::ACT_RESET: begin
				if (mode_q != epps_pkg::PMODE_NONE) begin
					ok_n    = 1'b1;
					mask_n  = MASK_HEAD | addr_mask | MASK_TAIL;
					mode_n  = epps_pkg::PMODE_NONE;
					vcc_n   = 1'b0;
					pulse_n = epps_pkg::PULSE_RST;
					vpp_n   = epps_pkg::VPP_25V;
					addr_n  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= epps_pkg::PMODE_NONE;
			vcc_q   <= 1'b0;
			pulse_q <= epps_pkg::PULSE_RST;
			vpp_q   <= epps_pkg::VPP_25V;
			addr_q  <= '0;
		end else if (cmd.capture) begin
			mode_q  <= mode_n;
			vcc_q   <= vcc_n;
			pulse_q <= pulse_n;
			vpp_q   <= vpp_n;
			addr_q  <= addr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= in_act;
			mv_q    <= in_mv;
			naddr_q <= tgt;
			data_q  <= in_data;
			en_q    <= in_en;
			mask_q  <= mask_n;
			ok_q    <= ok_n;
			rbyte_q <= (ok_n && in_act == epps_pkg::ACT_READ) ? ~in_rb : 8'd0;
			pok_q   <= ok_n && in_act == epps_pkg::ACT_TRIGGER && in_pd;
		end
	end

	// write generator for the current step
	logic [3:0]    vcc_nib, vpp_nib, pulse_nib, trig_base;
	logic [SW-1:0] ser_j, nib_j;
	logic [2:0]    ser_idx;
	logic [7:0]    hi_byte;
	logic          ser_bit;
	logic [2:0]    g_unit;
	logic [3:0]    g_nib;
	logic          g_strb;

	always_comb begin
		vcc_nib   = {vcc_q, 3'b000};
		pulse_nib = {2'b00, pulse_q};
		case (vpp_q)
			epps_pkg::VPP_12V: vpp_nib = 4'h4;
			epps_pkg::VPP_21V: vpp_nib = 4'h8;
			epps_pkg::VPP_25V: vpp_nib = 4'h0;
			default:           vpp_nib = 4'h4;
		endcase
		trig_base = vcc_nib | 4'h4;
		hi_byte   = naddr_q[AW-1:12];
		ser_j     = cmd.step - SW'(5);
		nib_j     = cmd.step - SW'(2);
		ser_idx   = 3'd7 - ser_j[3:1];
		ser_bit   = hi_byte[ser_idx];

		g_unit = epps_pkg::UNIT_DATA_LO;
		g_nib  = 4'h0;
		g_strb = 1'b1;
		case (act_q)
			epps_pkg::ACT_MODE: begin
				if (mv_q == 3'(epps_pkg::PMODE_READ)) begin
					if (cmd.step == '0) begin
						g_unit = epps_pkg::UNIT_PULSE;
						g_nib  = pulse_nib | 4'h4;
					end else begin
						g_unit = epps_pkg::UNIT_CTRL;
						g_nib  = vcc_nib | 4'h2;
					end
				end else if (mv_q == 3'(epps_pkg::PMODE_WRITE)) begin
					if (cmd.step == '0) begin
						g_unit = epps_pkg::UNIT_CTRL;
						g_nib  = vcc_nib | 4'h6;
					end else begin
						g_unit = epps_pkg::UNIT_PULSE;
						g_nib  = pulse_nib | 4'hC;
					end
				end else if (cmd.step == '0) begin
					g_unit = epps_pkg::UNIT_CTRL;
					g_nib  = 4'h2;
				end else if (cmd.step == SW'(1)) begin
					g_unit = epps_pkg::UNIT_PULSE;
					g_nib  = pulse_nib;
				end else begin
					g_unit = epps_pkg::UNIT_SERIAL;
					g_nib  = vpp_nib;
				end
			end
			epps_pkg::ACT_VPP: begin
				g_unit = epps_pkg::UNIT_SERIAL;
				g_nib  = vpp_nib;
			end
			epps_pkg::ACT_ADDRESS, epps_pkg::ACT_RESET: begin
				if (cmd.step == '0) begin
					g_unit = epps_pkg::UNIT_CTRL;
					g_nib  = 4'h2;
				end else if (cmd.step == SW'(1)) begin
					g_unit = epps_pkg::UNIT_PULSE;
					g_nib  = pulse_nib;
				end else if (cmd.step <= SW'(4)) begin
					g_unit = 3'(cmd.step);
					g_nib  = naddr_q[{nib_j[1:0], 2'b00} +: 4];
				end else if (cmd.step <= SW'(20)) begin
					// clock low then clock high, msb first
					g_unit = epps_pkg::UNIT_SERIAL;
					g_nib  = vpp_nib | {2'b00, ser_j[0], ser_bit};
				end else begin
					g_unit = epps_pkg::UNIT_SERIAL;
					g_nib  = vpp_nib;
				end
			end
			epps_pkg::ACT_WRITE: begin
				if (cmd.step == '0) begin
					g_unit = epps_pkg::UNIT_DATA_LO;
					g_nib  = data_q[3:0];
				end else begin
					g_unit = epps_pkg::UNIT_DATA_HI;
					g_nib  = data_q[7:4];
				end
			end
			epps_pkg::ACT_READ: begin
				g_unit = epps_pkg::UNIT_DATA_LO;
				g_nib  = {1'b0, cmd.step[2:0]};
				g_strb = 1'b0;
			end
			epps_pkg::ACT_TRIGGER: begin
				g_unit = epps_pkg::UNIT_CTRL;
				case (cmd.step)
					SW'(0), SW'(2): g_nib = trig_base;
					SW'(1):         g_nib = trig_base | 4'h1;
					SW'(3): begin
						g_unit = epps_pkg::UNIT_DATA_LO;
						g_nib  = {3'b000, pulse_q == 2'd0};
						g_strb = 1'b0;
					end
					default:        g_nib = trig_base | 4'h2;
				endcase
			end
			epps_pkg::ACT_OE: begin
				g_unit = epps_pkg::UNIT_CTRL;
				g_nib  = vcc_nib | 4'h2 | {3'b000, en_q};
			end
			default: begin
			end
		endcase
	end

	// output register
	logic       ovalid_q, owv_q, olast_q, ostrb_q, ook_q, opok_q;
	logic [2:0] ounit_q;
	logic [3:0] onib_q;
	logic [7:0] orbyte_q;

	assign stat.cur_emit         = mask_q[cmd.step];
	assign stat.rest_empty       = (mask_q >> cmd.step) == '0;
	assign stat.rest_after_empty = (mask_q >> SW'(cmd.step + SW'(1))) == '0;
	assign stat.out_free         = !ovalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			owv_q    <= stat.cur_emit;
			ounit_q  <= stat.cur_emit ? g_unit : 3'd0;
			onib_q   <= stat.cur_emit ? g_nib : 4'd0;
			ostrb_q  <= stat.cur_emit && g_strb;
			olast_q  <= stat.rest_after_empty;
			ook_q    <= stat.rest_after_empty && ok_q;
			orbyte_q <= stat.rest_after_empty ? rbyte_q : 8'd0;
			opok_q   <= stat.rest_after_empty && pok_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = owv_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {6'd0, opok_q, orbyte_q, ook_q, ostrb_q, onib_q, ounit_q};

endmodule

// File: src/epps_ctrl.sv
// controller: command handshake and step sequencing
module epps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  epps_pkg::dp_stat_t  stat,
	output epps_pkg::ctrl_cmd_t cmd
);

	localparam int SW = epps_pkg::STEP_W;

	epps_pkg::state_t state_q, state_n;
	logic [SW-1:0]    step_q;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epps_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.capture) begin
				step_q <= '0;
			end else if (advance) begin
				step_q <= step_q + SW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			epps_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_n = epps_pkg::ST_RUN;
				end
			end
			epps_pkg::ST_RUN: begin
				if (cmd.load && stat.rest_after_empty) begin
					state_n = epps_pkg::ST_IDLE;
				end
			end
			default: state_n = epps_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = step_q;
		advance     = 1'b0;
		unique case (state_q)
			epps_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			epps_pkg::ST_RUN: begin
				// a write at this step, or the lone no-write result
				cmd.load = stat.out_free && (stat.cur_emit || stat.rest_empty);
				advance  = (cmd.load && !stat.rest_after_empty) ||
					(!stat.cur_emit && !stat.rest_empty);
			end
			default: begin
			end
		endcase
	end

	ap_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < SW'(epps_pkg::NUM_STEPS))
		else $error("step counter beyond last slot");

	ap_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == epps_pkg::ST_RUN)
		else $error("result loaded outside run state");

	ap_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == epps_pkg::ST_RUN && step_q == '0)
		else $error("capture did not start the step sequence");

	ap_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !stat.cur_emit |-> stat.rest_after_empty)
		else $error("no-write result with writes still pending");

endmodule

// File: src/eprom_programmer_port_sequencer.sv
// top level of the programmer port sequencer
// usage:
//   commands arrive on the slave stream: s_tuser holds the command code,
//   s_tdata the operands (mode value, address, data byte, output enable
//   level, sensed read bits, sensed pulse-finished level).
//   each command yields up to 22 port writes on the master stream, one
//   result per transaction; m_tlast marks the final one, which also carries
//   the ok flag, the read byte and the pulse status. m_tuser says whether
//   the result holds a port write; a rejected command or one with nothing to
//   send gives a single result with m_tuser low.
// timing:
//   a command is taken while idle, then the sequencer walks a 22-slot step
//   counter, one slot a cycle unless stalled, a write leaving on each slot
//   that the command uses; it ends at the last slot that the command uses.
//   the next command is taken once the last result of the previous one has
//   been loaded into the output register, while that result still waits.
// reset: clears the modes to none, vcc select 0, pulse mode 3, 25 V vpp and the
//   kept address to zero; no result is pending.
// stall: a low m_tready holds the output register and the walk at a write slot.
module eprom_programmer_port_sequencer #(
	parameter int ADDRESS_BITS = epps_pkg::ADDRESS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// mode_value[2:0], address[22:3], data_byte[30:23], enable_flag[31],
	// read_back[39:32], pulse_done[40], zero fill
	input  logic [epps_pkg::S_TDATA_W-1:0] s_tdata,
	// action[3:0]
	input  logic [epps_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// port_unit[2:0], port_nibble[6:3], strobed[7], ok[8], read_byte[16:9],
	// pulse_ok[17], zero fill
	output logic [epps_pkg::M_TDATA_W-1:0] m_tdata,
	// write_valid[0]
	output logic                           m_tuser,
	output logic                           m_tlast
);

	// command and status between sequencer and datapath
	epps_pkg::ctrl_cmd_t cmd;
	epps_pkg::dp_stat_t  stat;

	epps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// selections, address tracking, write generation and output register
	epps_dp #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
